// ----- hdl/rled_pkg.sv -----
// ----------------------------------------------------------------------------
// rled_pkg
// Shared codes, widths and reset values for the RGB LED strip frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rled_pkg;

    localparam int MAX_LEDS_DEFAULT = 1024;

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 10;
    localparam int COLOR_W  = 8;
    localparam int RGB_W    = 24;
    localparam int LEN_W    = 11;
    localparam int TICKS_W  = 15;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int BIT_CNT_W = 5;

    localparam logic [OP_W-1:0] OP_SET_PIXEL   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET_PIXEL   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_PIXEL = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd3;
    localparam logic [OP_W-1:0] OP_START_FRAME = 3'd4;
    localparam logic [OP_W-1:0] OP_PULL        = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS     = 3'd5;

    localparam logic [LEN_W-1:0]   RST_STRIP_LENGTH    = 11'd1;
    localparam logic [TICKS_W-1:0] RST_ONE_HIGH_TICKS  = 15'd64;
    localparam logic [TICKS_W-1:0] RST_ONE_LOW_TICKS   = 15'd32;
    localparam logic [TICKS_W-1:0] RST_ZERO_HIGH_TICKS = 15'd32;
    localparam logic [TICKS_W-1:0] RST_ZERO_LOW_TICKS  = 15'd64;
    localparam logic [TICKS_W-1:0] RST_LATCH_TICKS     = 15'd4000;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd23;

endpackage

`default_nettype wire

// ----- hdl/rled_pixel_ram.sv -----
// ----------------------------------------------------------------------------
// rled_pixel_ram
// Pixel store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_pixel_ram #(
    parameter int AW = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [rled_pkg::RGB_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [rled_pkg::RGB_W-1:0] rd_data_reg
);

    logic [rled_pkg::RGB_W-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rgb_led_strip_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_encoder
// Pixel store for an LED strip that encodes frames as pulse symbols, one LED
// per pull, one bit per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      op, pixel index, red, green, blue
//  m_        out        m_valid / m_ready      status, colors, symbol, last
//  cfg_      in         cfg_valid / cfg_ready  register index, data
//
//  After reset all 2**AW entries of the store (1024 by default) are cleared
//  in one pass while s_ready is low; configuration writes are taken throughout.
//  A pull that sends an LED does one memory read and one load of the bit
//  shift register, then sends 24 symbols, one per cycle while the output is not stalled.
//  Clear all zeroes each LED in use first; other items, bar a pull that sends an LED, go straight to their result.
//  A stalled output holds the sequencer; the next item is taken as soon as
//  the last result of the current one sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_strip_frame_encoder #(
    parameter int MAX_LEDS = rled_pkg::MAX_LEDS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rled_pkg::OP_W-1:0]     s_op,
    input  wire logic [rled_pkg::INDEX_W-1:0]  s_pixel_index,
    input  wire logic [rled_pkg::COLOR_W-1:0]  s_red_in,
    input  wire logic [rled_pkg::COLOR_W-1:0]  s_green_in,
    input  wire logic [rled_pkg::COLOR_W-1:0]  s_blue_in,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rled_pkg::STATUS_W-1:0] m_status,
    output logic      [rled_pkg::COLOR_W-1:0]  m_red_out,
    output logic      [rled_pkg::COLOR_W-1:0]  m_green_out,
    output logic      [rled_pkg::COLOR_W-1:0]  m_blue_out,
    output logic                               m_symbol_valid,
    output logic                               m_first_level,
    output logic      [rled_pkg::TICKS_W-1:0]  m_first_ticks,
    output logic      [rled_pkg::TICKS_W-1:0]  m_second_ticks,
    output logic                               m_frame_end,
    output logic                               m_last,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rled_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rled_pkg::TICKS_W-1:0]  cfg_data
);

    localparam int DEPTH = (MAX_LEDS < 2048) ? MAX_LEDS : 2048;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WIPE,
        S_LOAD,
        S_SHIFT,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [rled_pkg::LEN_W-1:0]   strip_length_reg;
    logic [rled_pkg::TICKS_W-1:0] one_high_ticks_reg;
    logic [rled_pkg::TICKS_W-1:0] one_low_ticks_reg;
    logic [rled_pkg::TICKS_W-1:0] zero_high_ticks_reg;
    logic [rled_pkg::TICKS_W-1:0] zero_low_ticks_reg;
    logic [rled_pkg::TICKS_W-1:0] latch_ticks_reg;

    logic [rled_pkg::LEN_W-1:0]     frame_pos_reg;
    logic                           frame_active_reg;
    logic [AW-1:0]                  wipe_reg;
    logic [rled_pkg::RGB_W-1:0]     shift_reg;
    logic [rled_pkg::BIT_CNT_W-1:0] bit_cnt_reg;
    logic [rled_pkg::STATUS_W-1:0]  res_status_reg;
    logic [rled_pkg::STATUS_W-1:0]  res_status_next;
    logic                           res_get_reg;
    logic                           res_latch_reg;

    logic                           m_valid_reg;
    logic [rled_pkg::STATUS_W-1:0]  m_status_reg;
    logic [rled_pkg::RGB_W-1:0]     m_rgb_reg;
    logic                           m_symbol_valid_reg;
    logic                           m_first_level_reg;
    logic [rled_pkg::TICKS_W-1:0]   m_first_ticks_reg;
    logic [rled_pkg::TICKS_W-1:0]   m_second_ticks_reg;
    logic                           m_frame_end_reg;
    logic                           m_last_reg;

    logic [rled_pkg::LEN_W-1:0]  len;
    logic                        in_range;
    logic                        s_fire;
    logic                        out_free;
    logic                        res_load;
    logic                        wipe_done;
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [rled_pkg::RGB_W-1:0]  mem_wr_data;
    logic [AW-1:0]               mem_rd_addr;
    logic [rled_pkg::RGB_W-1:0]  mem_rd_data;
    logic                        cur_bit;

    assign len = (32'(strip_length_reg) > 32'(MAX_LEDS)) ? rled_pkg::LEN_W'(MAX_LEDS)
                                                         : strip_length_reg;
    assign in_range  = {1'b0, s_pixel_index} < len;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign res_load  = out_free && (state_reg == S_SHIFT || state_reg == S_EMIT);
    assign cfg_ready = 1'b1;
    assign wipe_done = (12'(wipe_reg) + 12'd1) >= 12'(len);
    assign cur_bit   = shift_reg[rled_pkg::RGB_W-1];

    always_comb begin
        res_status_next = rled_pkg::ST_OK;
        case (s_op)
            rled_pkg::OP_SET_PIXEL, rled_pkg::OP_GET_PIXEL, rled_pkg::OP_CLEAR_PIXEL: begin
                if (!in_range) begin
                    res_status_next = rled_pkg::ST_RANGE;
                end
            end
            rled_pkg::OP_PULL: begin
                if (!frame_active_reg) begin
                    res_status_next = rled_pkg::ST_NO_FRAME;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = wipe_reg;
        mem_wr_data = '0;
        if (state_reg == S_INIT || state_reg == S_WIPE) begin
            mem_wr_en = 1'b1;
        end else if (s_fire && in_range &&
                     (s_op == rled_pkg::OP_SET_PIXEL || s_op == rled_pkg::OP_CLEAR_PIXEL)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(s_pixel_index);
            if (s_op == rled_pkg::OP_SET_PIXEL) begin
                mem_wr_data = {s_red_in, s_green_in, s_blue_in};
            end
        end
    end

    assign mem_rd_addr = (s_op == rled_pkg::OP_PULL) ? AW'(frame_pos_reg)
                                                     : AW'(s_pixel_index);

    rled_pixel_ram #(
        .AW (AW)
    ) u_pixel_ram (
        .aclk        (aclk),
        .wr_en       (mem_wr_en),
        .wr_addr     (mem_wr_addr),
        .wr_data     (mem_wr_data),
        .rd_en       (s_fire),
        .rd_addr     (mem_rd_addr),
        .rd_data_reg (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_length_reg    <= rled_pkg::RST_STRIP_LENGTH;
            one_high_ticks_reg  <= rled_pkg::RST_ONE_HIGH_TICKS;
            one_low_ticks_reg   <= rled_pkg::RST_ONE_LOW_TICKS;
            zero_high_ticks_reg <= rled_pkg::RST_ZERO_HIGH_TICKS;
            zero_low_ticks_reg  <= rled_pkg::RST_ZERO_LOW_TICKS;
            latch_ticks_reg     <= rled_pkg::RST_LATCH_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rled_pkg::CFG_STRIP_LENGTH:    strip_length_reg <= cfg_data[rled_pkg::LEN_W-1:0];
                rled_pkg::CFG_ONE_HIGH_TICKS:  one_high_ticks_reg  <= cfg_data;
                rled_pkg::CFG_ONE_LOW_TICKS:   one_low_ticks_reg   <= cfg_data;
                rled_pkg::CFG_ZERO_HIGH_TICKS: zero_high_ticks_reg <= cfg_data;
                rled_pkg::CFG_ZERO_LOW_TICKS:  zero_low_ticks_reg  <= cfg_data;
                rled_pkg::CFG_LATCH_TICKS:     latch_ticks_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_INIT;
            wipe_reg         <= '0;
            frame_pos_reg    <= '0;
            frame_active_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: begin
                    wipe_reg <= wipe_reg + 1'b1;
                    if (&wipe_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        res_status_reg <= res_status_next;
                        res_get_reg    <= (s_op == rled_pkg::OP_GET_PIXEL) && in_range;
                        res_latch_reg  <= (s_op == rled_pkg::OP_PULL) && frame_active_reg &&
                                          (frame_pos_reg >= len);
                        unique case (s_op)
                            rled_pkg::OP_CLEAR_ALL: begin
                                wipe_reg  <= '0;
                                state_reg <= (len != '0) ? S_WIPE : S_EMIT;
                            end
                            rled_pkg::OP_START_FRAME: begin
                                frame_active_reg <= 1'b1;
                                frame_pos_reg    <= '0;
                                state_reg        <= S_EMIT;
                            end
                            rled_pkg::OP_PULL: begin
                                if (!frame_active_reg) begin
                                    state_reg <= S_EMIT;
                                end else if (frame_pos_reg >= len) begin
                                    frame_active_reg <= 1'b0;
                                    frame_pos_reg    <= '0;
                                    state_reg        <= S_EMIT;
                                end else begin
                                    frame_pos_reg <= frame_pos_reg + 1'b1;
                                    state_reg     <= S_LOAD;
                                end
                            end
                            default: state_reg <= S_EMIT;
                        endcase
                    end
                end
                S_WIPE: begin
                    wipe_reg <= wipe_reg + 1'b1;
                    if (wipe_done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_LOAD: begin
                    shift_reg   <= {mem_rd_data[15:8], mem_rd_data[23:16], mem_rd_data[7:0]};
                    bit_cnt_reg <= '0;
                    state_reg   <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (out_free) begin
                        m_status_reg       <= rled_pkg::ST_OK;
                        m_rgb_reg          <= '0;
                        m_symbol_valid_reg <= 1'b1;
                        m_first_level_reg  <= 1'b1;
                        m_first_ticks_reg  <= cur_bit ? one_high_ticks_reg : zero_high_ticks_reg;
                        m_second_ticks_reg <= cur_bit ? one_low_ticks_reg : zero_low_ticks_reg;
                        m_frame_end_reg    <= 1'b0;
                        m_last_reg         <= (bit_cnt_reg == rled_pkg::LAST_BIT);
                        shift_reg          <= shift_reg << 1;
                        bit_cnt_reg        <= bit_cnt_reg + 1'b1;
                        if (bit_cnt_reg == rled_pkg::LAST_BIT) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_status_reg       <= res_status_reg;
                        m_rgb_reg          <= res_get_reg ? mem_rd_data : '0;
                        m_symbol_valid_reg <= res_latch_reg;
                        m_first_level_reg  <= 1'b0;
                        m_first_ticks_reg  <= res_latch_reg ? latch_ticks_reg : '0;
                        m_second_ticks_reg <= '0;
                        m_frame_end_reg    <= res_latch_reg;
                        m_last_reg         <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_red_out      = m_rgb_reg[23:16];
    assign m_green_out    = m_rgb_reg[15:8];
    assign m_blue_out     = m_rgb_reg[7:0];
    assign m_symbol_valid = m_symbol_valid_reg;
    assign m_first_level  = m_first_level_reg;
    assign m_first_ticks  = m_first_ticks_reg;
    assign m_second_ticks = m_second_ticks_reg;
    assign m_frame_end    = m_frame_end_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire

// ----- hdl/rled_checker.sv -----
// ----------------------------------------------------------------------------
// rled_checker
// Port-level checks on the result channel and the start-up clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [rled_pkg::STATUS_W-1:0] m_status,
    input wire logic [rled_pkg::COLOR_W-1:0]  m_red_out,
    input wire logic [rled_pkg::COLOR_W-1:0]  m_green_out,
    input wire logic [rled_pkg::COLOR_W-1:0]  m_blue_out,
    input wire logic                          m_symbol_valid,
    input wire logic                          m_first_level,
    input wire logic [rled_pkg::TICKS_W-1:0]  m_first_ticks,
    input wire logic [rled_pkg::TICKS_W-1:0]  m_second_ticks,
    input wire logic                          m_frame_end,
    input wire logic                          m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_first_ticks)
            && $stable(m_second_ticks) && $stable(m_last) && $stable(m_symbol_valid))
        else $error("result changed while stalled");

    a_init: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("item taken before the store was cleared");

    a_data_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_symbol_valid && !m_frame_end |-> m_first_level && m_status == '0)
        else $error("data symbol with wrong level or status");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_last && m_symbol_valid && !m_first_level
            && m_second_ticks == '0)
        else $error("malformed end of frame symbol");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != '0 |-> !m_symbol_valid && m_last && m_red_out == '0
            && m_green_out == '0 && m_blue_out == '0)
        else $error("error result carries payload");

endmodule

bind rgb_led_strip_frame_encoder rled_checker u_rled_checker (.*);

`default_nettype wire
